// ----- hdl/wmds_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wmds_pkg
// shared types and constants for the window mean deviation score block
// ----------------------------------------------------------------------------
package wmds_pkg;

    // configuration register indexes
    localparam logic [0:0] CFG_WINDOW_LENGTH = 1'b0;
    localparam logic [0:0] CFG_SCORE_OFFSET  = 1'b1;
    localparam int unsigned CFG_IDX_BITS     = 1;

    // window length after reset, clamped to the store depth where it is smaller
    localparam int unsigned WIN_LEN_RESET = 16;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOAD,
        S_DIV,
        S_DONE
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic load;
        logic step;
        logic commit;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic div_last;
        logic out_free;
    } t_dp_sts;

endpackage

// ----- hdl/wmds_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wmds_ctrl
// sequencer: take a sample, run the serial divide, commit the score
// ----------------------------------------------------------------------------
module wmds_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  wmds_pkg::t_dp_sts i_sts,
    output wmds_pkg::t_dp_cmd o_cmd
);

    wmds_pkg::t_state r_state;
    wmds_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= wmds_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            wmds_pkg::S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = wmds_pkg::S_LOAD;
                end
            end
            wmds_pkg::S_LOAD: begin
                o_cmd.load = 1'b1;
                n_state    = wmds_pkg::S_DIV;
            end
            wmds_pkg::S_DIV: begin
                o_cmd.step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = wmds_pkg::S_DONE;
                end
            end
            wmds_pkg::S_DONE: begin
                // wait here while the previous score is still held
                if (i_sts.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = wmds_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = wmds_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// ----- hdl/wmds_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wmds_dp
// history ring, running sum, serial divider and score register
// ----------------------------------------------------------------------------
module wmds_dp #(
    parameter int unsigned MAX_WINDOW  = 64,
    parameter int unsigned SAMPLE_BITS = 32
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_we,
    input  logic [wmds_pkg::CFG_IDX_BITS-1:0]      i_cfg_idx,
    input  logic [((SAMPLE_BITS > $clog2(MAX_WINDOW + 1)) ? SAMPLE_BITS
                   : $clog2(MAX_WINDOW + 1))-1:0] i_cfg_data,
    input  logic signed [SAMPLE_BITS-1:0]          i_sample,
    input  logic                                   i_restart_first,
    input  wmds_pkg::t_dp_cmd                      i_cmd,
    output wmds_pkg::t_dp_sts                      o_sts,
    input  logic                                   i_out_stall,
    output logic                                   o_out_valid,
    output logic signed [SAMPLE_BITS+1:0]          o_score
);

    localparam int unsigned CNT_BITS   = $clog2(MAX_WINDOW + 1);
    localparam int unsigned POS_BITS   = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int unsigned SUM_BITS   = SAMPLE_BITS + $clog2(MAX_WINDOW);
    localparam int unsigned EXT_BITS   = SUM_BITS + 2;
    localparam int unsigned SCORE_BITS = SAMPLE_BITS + 2;
    localparam int unsigned STEP_BITS  = $clog2(SUM_BITS);
    localparam int unsigned LEN_RST    = (wmds_pkg::WIN_LEN_RESET > MAX_WINDOW)
                                         ? MAX_WINDOW : wmds_pkg::WIN_LEN_RESET;

    // configuration
    logic        [CNT_BITS-1:0]    r_win_len;
    logic signed [SAMPLE_BITS-1:0] r_offset;

    // window state
    logic        [POS_BITS-1:0]    r_wpos;
    logic        [CNT_BITS-1:0]    r_count;
    logic signed [SUM_BITS-1:0]    r_sum;
    logic signed [SAMPLE_BITS-1:0] r_hist [MAX_WINDOW];

    // item in flight
    logic signed [SAMPLE_BITS-1:0] r_sample;
    logic        [POS_BITS-1:0]    r_pos;
    logic signed [SAMPLE_BITS-1:0] r_rd;
    logic signed [EXT_BITS-1:0]    r_base;

    // divider
    logic        [CNT_BITS:0]      r_rem;
    logic        [SUM_BITS-1:0]    r_quo;
    logic                          r_neg;
    logic        [STEP_BITS-1:0]   r_step;

    logic                          r_out_valid;
    logic signed [SCORE_BITS-1:0]  r_score;

    logic        [CNT_BITS-1:0]    w_len;
    logic        [POS_BITS-1:0]    w_pos;
    logic        [CNT_BITS-1:0]    w_pos_inc;
    logic                          w_full;
    logic        [CNT_BITS:0]      w_shift;
    logic                          w_ge;
    logic signed [EXT_BITS-1:0]    w_q;
    logic signed [EXT_BITS-1:0]    w_score;
    logic signed [SUM_BITS-1:0]    w_drop;

    // effective window length: zero acts as one, clamp at the store depth
    always_comb begin
        if (r_win_len == '0) begin
            w_len = CNT_BITS'(1);
        end else if (r_win_len > CNT_BITS'(MAX_WINDOW)) begin
            w_len = CNT_BITS'(MAX_WINDOW);
        end else begin
            w_len = r_win_len;
        end
    end

    assign w_pos     = (CNT_BITS'(r_wpos) >= w_len) ? '0 : r_wpos;
    assign w_pos_inc = CNT_BITS'(r_pos) + CNT_BITS'(1);
    assign w_full    = (r_count >= w_len);

    // restoring divide step on magnitudes
    assign w_shift = {r_rem[CNT_BITS-1:0], r_quo[SUM_BITS-1]};
    assign w_ge    = (w_shift >= {1'b0, r_count});

    assign w_q     = EXT_BITS'(r_quo);
    always_comb begin
        if (r_count == '0) begin
            w_score = r_base;
        end else if (r_neg) begin
            w_score = r_base + w_q;
        end else begin
            w_score = r_base - w_q;
        end
    end

    assign w_drop = w_full ? SUM_BITS'(r_rd) : '0;

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_len   <= CNT_BITS'(LEN_RST);
            r_offset    <= '0;
            r_wpos      <= '0;
            r_count     <= '0;
            r_sum       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == wmds_pkg::CFG_WINDOW_LENGTH) begin
                    r_win_len <= i_cfg_data[CNT_BITS-1:0];
                end else begin
                    r_offset  <= i_cfg_data[SAMPLE_BITS-1:0];
                end
            end
            priority if ((i_cfg_we && i_cfg_idx == wmds_pkg::CFG_WINDOW_LENGTH)
                         || (i_cmd.accept && i_restart_first)) begin
                r_wpos  <= '0;
                r_count <= '0;
                r_sum   <= '0;
            end else if (i_cmd.commit) begin
                r_sum   <= r_sum + SUM_BITS'(r_sample) - w_drop;
                r_count <= w_full ? w_len : r_count + CNT_BITS'(1);
                r_wpos  <= (w_pos_inc >= w_len) ? '0 : POS_BITS'(w_pos_inc);
            end else begin
                r_wpos  <= r_wpos;
                r_count <= r_count;
                r_sum   <= r_sum;
            end
            if (i_cmd.commit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_sample <= i_sample;
        end
        if (i_cmd.load) begin
            r_pos  <= w_pos;
            r_rem  <= '0;
            r_neg  <= r_sum[SUM_BITS-1];
            r_quo  <= r_sum[SUM_BITS-1] ? SUM_BITS'(-r_sum) : SUM_BITS'(r_sum);
            r_step <= '0;
            r_base <= (r_count == '0) ? -EXT_BITS'(r_offset)
                                      : EXT_BITS'(r_sample) - EXT_BITS'(r_offset);
        end
        if (i_cmd.step) begin
            r_rem  <= w_ge ? (w_shift - {1'b0, r_count}) : w_shift;
            r_quo  <= {r_quo[SUM_BITS-2:0], w_ge};
            r_step <= r_step + STEP_BITS'(1);
        end
        if (i_cmd.commit) begin
            r_score <= SCORE_BITS'(w_score);
        end
    end

    // history ring, read registered
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_rd <= r_hist[w_pos];
        end
        if (i_cmd.commit) begin
            r_hist[r_pos] <= r_sample;
        end
    end

    assign o_sts.div_last = (r_step == STEP_BITS'(SUM_BITS - 1));
    assign o_sts.out_free = !r_out_valid || !i_out_stall;
    assign o_out_valid    = r_out_valid;
    assign o_score        = r_score;

endmodule

// ----- hdl/window_mean_deviation_score.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// window_mean_deviation_score
// per-sample moving-mean deviation score over a ring of past samples
// ----------------------------------------------------------------------------
//  channel  direction  handshake                  payload
//  in       sink       i_in_valid / o_in_stall    i_sample, i_restart_first
//  out      source     o_out_valid / i_out_stall  o_score
//  cfg      sink       i_cfg_we                   i_cfg_idx, i_cfg_data
//
//  one transfer at a time: an accept, a load with the ring read, SUM_BITS
//  steps of the one-bit restoring divider for sum / count, and a commit;
//  the next sample is taken only after the commit
//  synchronous active-low reset resets config, ring pointer, count, sum and
//  the output valid; ring contents are not cleared
//  a held score does not block the next sample; only the commit waits for it
// ----------------------------------------------------------------------------
module window_mean_deviation_score #(
    parameter int unsigned MAX_WINDOW  = 64,
    parameter int unsigned SAMPLE_BITS = 32
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // configuration writes
    input  logic                                   i_cfg_we,
    input  logic [wmds_pkg::CFG_IDX_BITS-1:0]      i_cfg_idx,
    input  logic [((SAMPLE_BITS > $clog2(MAX_WINDOW + 1)) ? SAMPLE_BITS
                   : $clog2(MAX_WINDOW + 1))-1:0] i_cfg_data,
    // sample channel
    input  logic                                   i_in_valid,
    output logic                                   o_in_stall,
    input  logic signed [SAMPLE_BITS-1:0]          i_sample,
    input  logic                                   i_restart_first,
    // score channel
    output logic                                   o_out_valid,
    input  logic                                   i_out_stall,
    output logic signed [SAMPLE_BITS+1:0]          o_score
);

    wmds_pkg::t_dp_cmd w_cmd;
    wmds_pkg::t_dp_sts w_sts;

    // sequencer: idle -> load -> divide -> commit
    wmds_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // ring, running sum, divider and output register
    wmds_dp #(
        .MAX_WINDOW  (MAX_WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_sample        (i_sample),
        .i_restart_first (i_restart_first),
        .i_cmd           (w_cmd),
        .o_sts           (w_sts),
        .i_out_stall     (i_out_stall),
        .o_out_valid     (o_out_valid),
        .o_score         (o_score)
    );

    // a sample transfer closes the input until its score is committed
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input open in the cycle after a sample transfer");

    // a commit never overwrites a score that is still held
    a_commit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.commit |-> (!o_out_valid || !i_out_stall))
        else $error("score committed over a stalled result");

    // a new score appears only from a commit
    a_valid_from_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(w_cmd.commit))
        else $error("output valid without a commit");

    // the sequencer issues at most one command per cycle
    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({w_cmd.accept, w_cmd.load, w_cmd.step, w_cmd.commit}))
        else $error("more than one datapath command");

endmodule
